/* rtl/stsq_pkg.sv */
// shared types, register codes and sine-squared table math for the stereo tremolo
package stsq_pkg;

  localparam int GAIN_W = 17;
  localparam int PHASE_W = 32;
  localparam int COUNT_W = 18;
  localparam int DEPTH_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int FOLD_W = 31;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [GAIN_W-1:0] ONE_Q16 = 17'h10000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEPTH     = 2'd0,
    REG_PHASE_INC = 2'd1,
    REG_PERIOD    = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FOLD,
    S_INDEX,
    S_ROM,
    S_GAIN_START,
    S_GAIN_WAIT,
    S_GAIN,
    S_OUT_START,
    S_OUT_WAIT,
    S_FINISH
  } state_t;

  // sin^2 in Q16 from a Q30 angle, truncated taylor series as fixed integer steps
  function automatic logic [GAIN_W-1:0] sine_sq_q16(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint sum;
    logic [63:0] s;
    logic [63:0] sq;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > 64'sd1073741824) begin
      sum = 64'sd1073741824;
    end
    s = 64'(sum);
    sq = (s * s + (64'd1 << 43)) >> 44;
    if (sq > 64'd65536) begin
      sq = 64'd65536;
    end
    return sq[GAIN_W-1:0];
  endfunction

endpackage

/* rtl/stsq_ser_mul.sv */
// bit-serial signed by unsigned multiplier, one multiplier bit per cycle
module stsq_ser_mul #(
  parameter int AW = 25,
  parameter int BW = 17
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [AW-1:0]    a,
  input  logic        [BW-1:0]    b,
  output logic                    done,
  output logic signed [AW+BW-1:0] product
);

  localparam int CW = $clog2(BW + 1);

  logic signed [AW-1:0] mcand;
  logic signed [AW:0]   hi;
  logic        [BW-1:0] lo;
  logic        [CW-1:0] cnt;
  logic signed [AW+1:0] sum;

  // upper partial product plus multiplicand when the current bit is set
  always_comb begin
    sum = {hi[AW], hi} + (lo[0] ? {{2{mcand[AW-1]}}, mcand} : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(BW);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      hi    <= '0;
      lo    <= b;
    end else if (cnt != '0) begin
      hi <= sum[AW+1:1];
      lo <= {sum[0], lo[BW-1:1]};
    end
  end

  assign done    = (cnt == '0);
  assign product = signed'({hi[AW-1:0], lo});

endmodule

/* rtl/stereo_tremolo_sine_squared_unit.sv */
// stereo tremolo: frame counter, phase accumulator, sine-squared gain, bit-serial scaling
// steps: fold, index, table read, gain multiply, gain register, sample multiplies, finish
// one frame at a time, the next taken once the previous leaves the finish step; the bulk
//   is two 17-step bit-serial multiplies (depth times 1 - table, then samples times gain)
// a new request is taken while the previous result still waits in the output register
// reset: registers to their defaults, frame count to one, phase to zero, no result pending
module stereo_tremolo_sine_squared_unit #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [stsq_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [stsq_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]        left_sample,
  input  logic signed [SAMPLE_WIDTH-1:0]        right_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]        left_out,
  output logic signed [SAMPLE_WIDTH-1:0]        right_out
);

  import stsq_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int AW = SW + 1;
  localparam int PW = AW + GAIN_W;
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int IPROD_W = FOLD_W + IDX_W;
  localparam logic signed [SW+1:0] SAT_HI = {3'b000, {(SW-1){1'b1}}};
  localparam logic signed [SW+1:0] SAT_LO = {3'b111, {(SW-1){1'b0}}};

  state_t state, state_next;

  logic [DEPTH_W-1:0]  depth;
  logic [PHASE_W-1:0]  phase_increment;
  logic [COUNT_W-1:0]  period_length;
  logic [COUNT_W-1:0]  frame_count;
  logic [PHASE_W-1:0]  lfo_phase;

  logic signed [SW-1:0] left_hold;
  logic signed [SW-1:0] right_hold;
  logic [FOLD_W-1:0]    fold_q;
  logic [IDX_W-1:0]     rom_idx;
  logic [GAIN_W-1:0]    sq_val;
  logic [GAIN_W-1:0]    gain;

  logic [GAIN_W-1:0] rom [SINE_TABLE_DEPTH+1];

  logic                 in_fire;
  logic                 gain_start;
  logic                 out_start;
  logic                 left_done;
  logic                 right_done;
  logic signed [AW-1:0] left_a;
  logic [GAIN_W-1:0]    left_b;
  logic signed [PW-1:0] left_prod;
  logic signed [PW-1:0] right_prod;

  logic [IPROD_W-1:0]   idx_prod;
  logic [IDX_W:0]       idx_raw;
  logic [FOLD_W-1:0]    q_raw;
  logic [32:0]          gain_sum;

  // quarter-wave sine-squared table, fixed at elaboration
  for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_rom
    localparam logic [63:0] ANGLE = (PI_HALF_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
    assign rom[i] = sine_sq_q16(ANGLE);
  end

  function automatic logic signed [SW-1:0] round_sat(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] r;
    logic signed [SW+1:0] t;
    r = p + PW'(32768);
    t = signed'(r[PW-1:16]);
    if (t > SAT_HI) begin
      t = SAT_HI;
    end else if (t < SAT_LO) begin
      t = SAT_LO;
    end
    return t[SW-1:0];
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      depth           <= 16'd32768;
      phase_increment <= '0;
      period_length   <= 18'd48000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEPTH:     depth           <= cfg_data[DEPTH_W-1:0];
        REG_PHASE_INC: phase_increment <= cfg_data[PHASE_W-1:0];
        REG_PERIOD:    period_length   <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_fire = in_valid && in_ready;

  // frame counter and phase accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= COUNT_W'(1);
      lfo_phase   <= '0;
    end else if (in_fire) begin
      if (frame_count < period_length) begin
        frame_count <= frame_count + 1'b1;
        lfo_phase   <= lfo_phase + phase_increment;
      end else begin
        frame_count <= '0;
        lfo_phase   <= '0;
      end
    end
  end

  always_comb begin
    q_raw    = lfo_phase[FOLD_W-1:0];
    idx_prod = IPROD_W'(fold_q) * IPROD_W'(SINE_TABLE_DEPTH);
    idx_raw  = idx_prod[IPROD_W-1:30];
    gain_sum = 33'h1_0000_8000 - {1'b0, left_prod[31:0]};
  end

  // datapath registers stepped by the sequencer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      left_hold  <= left_sample;
      right_hold <= right_sample;
    end
    if (state == S_FOLD) begin
      // sin^2 repeats each half turn and mirrors about the quarter turn
      if (q_raw[FOLD_W-1]) begin
        fold_q <= 31'h4000_0000 - {1'b0, q_raw[FOLD_W-2:0]};
      end else begin
        fold_q <= q_raw;
      end
    end
    if (state == S_INDEX) begin
      if (idx_raw > (IDX_W+1)'(SINE_TABLE_DEPTH)) begin
        rom_idx <= IDX_W'(SINE_TABLE_DEPTH);
      end else begin
        rom_idx <= idx_raw[IDX_W-1:0];
      end
    end
    if (state == S_ROM) begin
      sq_val <= rom[rom_idx];
    end
    if (state == S_GAIN) begin
      gain <= gain_sum[32:16];
    end
  end

  // output register, freed by the consumer independently of the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && (!out_valid || out_ready)) begin
      left_out  <= round_sat(left_prod);
      right_out <= round_sat(right_prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    gain_start = 1'b0;
    out_start  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_FOLD;
        end
      end
      S_FOLD:  state_next = S_INDEX;
      S_INDEX: state_next = S_ROM;
      S_ROM:   state_next = S_GAIN_START;
      S_GAIN_START: begin
        gain_start = 1'b1;
        state_next = S_GAIN_WAIT;
      end
      S_GAIN_WAIT: begin
        if (left_done) begin
          state_next = S_GAIN;
        end
      end
      S_GAIN: state_next = S_OUT_START;
      S_OUT_START: begin
        out_start  = 1'b1;
        state_next = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (left_done && right_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // left multiplier also forms depth * (1 - sin^2) for the gain
  always_comb begin
    if (state == S_GAIN_START) begin
      left_a = signed'({{(AW-DEPTH_W){1'b0}}, depth});
      left_b = ONE_Q16 - sq_val;
    end else begin
      left_a = {left_hold[SW-1], left_hold};
      left_b = gain;
    end
  end

  stsq_ser_mul #(
    .AW(AW),
    .BW(GAIN_W)
  ) u_mul_left (
    .clk    (clk),
    .rst    (rst),
    .start  (gain_start || out_start),
    .a      (left_a),
    .b      (left_b),
    .done   (left_done),
    .product(left_prod)
  );

  stsq_ser_mul #(
    .AW(AW),
    .BW(GAIN_W)
  ) u_mul_right (
    .clk    (clk),
    .rst    (rst),
    .start  (out_start),
    .a      ({right_hold[SW-1], right_hold}),
    .b      (gain),
    .done   (right_done),
    .product(right_prod)
  );

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (frame_count == '0 || frame_count == $past(frame_count) + 1'b1))
    else $error("frame counter stepped wrongly");

  a_wrap_clears_phase: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (frame_count != '0 || lfo_phase == '0))
    else $error("phase not cleared on counter wrap");

  a_gain_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT_START) |-> (gain <= ONE_Q16))
    else $error("gain above unity");

  a_mul_idle_at_start: assert property (@(posedge clk) disable iff (rst)
    (gain_start || out_start) |-> (left_done && right_done))
    else $error("multiplier restarted while busy");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FINISH))
    else $error("result appeared outside finish step");

endmodule
